@@ rtl/rcpd_pkg.sv @@
package rcpd_pkg;

    localparam int PKT_W      = 42;
    localparam int DIG_N      = 9;
    localparam int SEQ_N      = 18;
    localparam int ACC_W      = 29;
    localparam int ROLL_W     = 28;
    localparam int FIX_W      = 20;
    localparam int STATUS_W   = 4;

    // status codes
    localparam logic [STATUS_W-1:0] ST_STORED   = 4'd0;
    localparam logic [STATUS_W-1:0] ST_DECODED  = 4'd1;
    localparam logic [STATUS_W-1:0] ST_ID       = 4'd2;
    localparam logic [STATUS_W-1:0] ST_REPEAT   = 4'd3;
    localparam logic [STATUS_W-1:0] ST_ORDER    = 4'd4;
    localparam logic [STATUS_W-1:0] ST_BAD_INV  = 4'd5;
    localparam logic [STATUS_W-1:0] ST_BAD_ORD  = 4'd6;
    localparam logic [STATUS_W-1:0] ST_DIGIT3   = 4'd7;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW = 4'd8;

    // one queued result: either a ready status or a pair to decode
    typedef struct packed {
        logic                dec;
        logic [STATUS_W-1:0] status;
        logic [PKT_W-1:0]    pk0;
        logic [PKT_W-1:0]    pk1;
    } t_job;

    typedef struct packed {
        logic [STATUS_W-1:0] err;
        logic [2*DIG_N-1:0]  dig;
        logic [FIX_W-1:0]    fix;
    } t_half;

    // invert nibble -> {valid, word invert mask}
    function automatic logic [3:0] inv_lookup(input logic [3:0] nib);
        logic [3:0] r;
        case (nib)
            4'd0:    r = {1'b1, 3'd3};
            4'd1:    r = {1'b1, 3'd2};
            4'd2:    r = {1'b1, 3'd4};
            4'd4:    r = {1'b1, 3'd7};
            4'd5:    r = {1'b1, 3'd5};
            4'd6:    r = {1'b1, 3'd6};
            4'd8:    r = {1'b1, 3'd1};
            4'd9:    r = {1'b1, 3'd0};
            4'd10:   r = {1'b1, 3'd5};
            default: r = 4'd0;
        endcase
        return r;
    endfunction

    // order nibble -> {valid, dst of word2, dst of word1, dst of word0}
    function automatic logic [6:0] ord_lookup(input logic [3:0] nib);
        logic [6:0] r;
        case (nib)
            4'd0:    r = {1'b1, 2'd1, 2'd2, 2'd0};
            4'd1:    r = {1'b1, 2'd1, 2'd0, 2'd2};
            4'd2:    r = {1'b1, 2'd2, 2'd1, 2'd0};
            4'd4:    r = {1'b1, 2'd0, 2'd2, 2'd1};
            4'd5:    r = {1'b1, 2'd2, 2'd0, 2'd1};
            4'd6:    r = {1'b1, 2'd0, 2'd1, 2'd2};
            4'd8:    r = {1'b1, 2'd0, 2'd2, 2'd1};
            4'd9:    r = {1'b1, 2'd0, 2'd1, 2'd2};
            4'd10:   r = {1'b1, 2'd2, 2'd1, 2'd0};
            default: r = 7'd0;
        endcase
        return r;
    endfunction

    // deinterleave, invert, reorder and pull the nine digits of one half
    function automatic t_half decode_half(input logic [PKT_W-1:0] pk);
        t_half      h;
        logic [9:0] w [3];
        logic [9:0] part [3];
        logic [7:0] hdr;
        logic [3:0] inv;
        logic [6:0] ord;
        logic       has3;
        hdr  = pk[37:30];
        inv  = inv_lookup(hdr[3:0]);
        ord  = ord_lookup(hdr[7:4]);
        has3 = 1'b0;
        for (int i = 0; i < 10; i++) begin
            w[2][i] = pk[3*i];
            w[1][i] = pk[3*i+1];
            w[0][i] = pk[3*i+2];
        end
        for (int i = 0; i < 3; i++) begin
            if (inv[i]) begin
                w[i] = ~w[i];
            end
        end
        for (int k = 0; k < 3; k++) begin
            part[k] = 10'd0;
        end
        for (int i = 0; i < 3; i++) begin
            for (int k = 0; k < 3; k++) begin
                if (ord[2*i+:2] == 2'(k)) begin
                    part[k] = w[i];
                end
            end
        end
        for (int i = 0; i < 4; i++) begin
            h.dig[2*i+:2] = hdr[6-2*i+:2];
        end
        for (int i = 0; i < 5; i++) begin
            h.dig[2*(4+i)+:2] = part[2][8-2*i+:2];
        end
        for (int i = 0; i < DIG_N; i++) begin
            if (h.dig[2*i+:2] == 2'd3) begin
                has3 = 1'b1;
            end
        end
        h.fix = {part[0], part[1]};
        if (!inv[3]) begin
            h.err = ST_BAD_INV;
        end else if (!ord[6]) begin
            h.err = ST_BAD_ORD;
        end else if (has3) begin
            h.err = ST_DIGIT3;
        end else begin
            h.err = ST_STORED;
        end
        return h;
    endfunction

endpackage

@@ rtl/rolling_code_packet_pair_decoder_top.sv @@
// rolling code packet pair decoder
//
// input stream: one demodulated 42-bit packet per transaction on the s_axis
// group. a packet with type zero is a first half and is held; a packet with
// nonzero type is a second half. every packet gives exactly one result.
// output stream: one result per transaction on the m_axis group, status on
// tuser, fixed code, button, rolling count and packed value on tdata.
// a status-only result (half stored, id, repeat, wrong order, or a
// table/digit error) passes through the job queue into the output
// register. a decoded pair stays in the back end while the rolling count is
// built one ternary digit per cycle by a multiply-by-three accumulator;
// the back end takes no new job until that pair's result is loaded.
// the front end keeps taking packets while the 2-entry job queue has room.
// reset: synchronous, active low; clears the pairing state, the queue and
// the output valid.
// stall: a held result stays on the output until taken; the queue fills and
// then s_axis tready drops.
module rolling_code_packet_pair_decoder_top (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    input  logic [47:0]  i_s_axis_tdata,    // [41:0] packet, rest zero
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    output logic [119:0] o_m_axis_tdata,    // [39:0] fixed_code, [47:40] button,
                                            // [75:48] rolling, [115:76] packed_value
    output logic [3:0]   o_m_axis_tuser     // [3:0] status
);
    import rcpd_pkg::*;

    t_job                job_in;
    t_job                job_head;
    logic                push;
    logic                pop;
    logic                q_full;
    logic                q_valid;
    logic [STATUS_W-1:0] status;
    logic [39:0]         fixed_code;
    logic [7:0]          button;
    logic [ROLL_W-1:0]   rolling;
    logic [39:0]         packed_value;

    // front end: classify each packet and update the pairing state
    rcpd_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_s_axis_tvalid),
        .i_packet (i_s_axis_tdata[PKT_W-1:0]),
        .i_q_full (q_full),
        .o_ready  (o_s_axis_tready),
        .o_push   (push),
        .o_job    (job_in)
    );

    // short job queue decoupling classification from decode
    rcpd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (job_in),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_job   (job_head)
    );

    // back end: pair decode, rolling count accumulation, output register
    rcpd_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_job_valid    (q_valid),
        .i_job          (job_head),
        .o_pop          (pop),
        .o_valid        (o_m_axis_tvalid),
        .i_ready        (i_m_axis_tready),
        .o_status       (status),
        .o_fixed_code   (fixed_code),
        .o_button       (button),
        .o_rolling      (rolling),
        .o_packed_value (packed_value)
    );

    assign o_m_axis_tuser = status;
    assign o_m_axis_tdata = {4'd0, packed_value, rolling, button, fixed_code};

endmodule

@@ rtl/rcpd_front.sv @@
module rcpd_front (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    input  logic [rcpd_pkg::PKT_W-1:0] i_packet,
    input  logic                   i_q_full,
    output logic                   o_ready,
    output logic                   o_push,
    output rcpd_pkg::t_job         o_job
);
    import rcpd_pkg::*;

    logic [PKT_W-1:0] r_first;
    logic [1:0]       r_seen;
    logic [PKT_W-1:0] n_first;
    logic [1:0]       n_seen;
    logic [1:0]       half_bit;
    logic [1:0]       merged;

    assign o_ready = !i_q_full;
    assign o_push  = i_valid && !i_q_full;

    always_comb begin
        half_bit    = (i_packet[41:40] != 2'd0) ? 2'b10 : 2'b01;
        merged      = r_seen | half_bit;
        n_first     = r_first;
        n_seen      = r_seen;
        o_job.dec    = 1'b0;
        o_job.status = ST_STORED;
        o_job.pk0    = r_first;
        o_job.pk1    = i_packet;
        if (i_packet[39:38] != 2'd0) begin
            n_seen       = 2'b00;
            o_job.status = ST_ID;
        end else if ((r_seen & half_bit) != 2'b00) begin
            n_seen       = 2'b00;
            o_job.status = ST_REPEAT;
        end else begin
            if (half_bit[0]) begin
                n_first = i_packet;
            end
            if (merged != 2'b11) begin
                n_seen       = merged;
                o_job.status = ST_STORED;
            end else if (half_bit[0]) begin
                // second half came first: restart with this packet
                n_seen       = 2'b01;
                o_job.status = ST_ORDER;
            end else begin
                n_seen    = 2'b00;
                o_job.dec = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first <= '0;
            r_seen  <= 2'b00;
        end else if (o_push) begin
            r_first <= n_first;
            r_seen  <= n_seen;
        end
    end

endmodule

@@ rtl/rcpd_queue.sv @@
module rcpd_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  rcpd_pkg::t_job i_job,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_valid,
    output rcpd_pkg::t_job o_job
);
    import rcpd_pkg::*;

    // two entries, head always in slot 0
    t_job       r_ent [2];
    logic [1:0] r_cnt;

    assign o_full  = r_cnt[1];
    assign o_valid = r_cnt != 2'd0;
    assign o_job   = r_ent[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            if (i_push && i_pop) begin
                if (r_cnt == 2'd1) begin
                    r_ent[0] <= i_job;
                end else begin
                    r_ent[0] <= r_ent[1];
                    r_ent[1] <= i_job;
                end
            end else if (i_push) begin
                r_ent[r_cnt[0]] <= i_job;
                r_cnt           <= r_cnt + 2'd1;
            end else if (i_pop) begin
                r_ent[0] <= r_ent[1];
                r_cnt    <= r_cnt - 2'd1;
            end
        end
    end

endmodule

@@ rtl/rcpd_back.sv @@
module rcpd_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_job_valid,
    input  rcpd_pkg::t_job                i_job,
    output logic                          o_pop,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [rcpd_pkg::STATUS_W-1:0] o_status,
    output logic [39:0]                   o_fixed_code,
    output logic [7:0]                    o_button,
    output logic [rcpd_pkg::ROLL_W-1:0]   o_rolling,
    output logic [39:0]                   o_packed_value
);
    import rcpd_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_ACC,
        S_DONE
    } t_state;

    t_state              r_state;
    logic [2*SEQ_N-1:0]  r_seq;
    logic [ACC_W-1:0]    r_acc;
    logic [4:0]          r_cnt;
    logic [FIX_W-1:0]    r_f0;
    logic [FIX_W-1:0]    r_f1;

    t_half               h0;
    t_half               h1;
    logic [STATUS_W-1:0] pair_err;
    logic [2*SEQ_N-1:0]  seq;
    logic                out_free;
    logic                out_load;
    logic [ROLL_W-1:0]   rev;
    logic [39:0]         pv;

    assign out_free = !o_valid || i_ready;
    assign o_pop    = (r_state == S_IDLE) && i_job_valid && out_free;
    // a new result enters the output register this cycle
    assign out_load = (o_pop && (!i_job.dec || pair_err != ST_STORED))
                    || ((r_state == S_DONE) && out_free);

    always_comb begin
        h0       = decode_half(i_job.pk0);
        h1       = decode_half(i_job.pk1);
        pair_err = (h0.err != ST_STORED) ? h0.err : h1.err;
        // most significant digit first
        seq = {h1.dig[17:16], h0.dig[17:16],
               h1.dig[9:8], h1.dig[11:10], h1.dig[13:12], h1.dig[15:14],
               h0.dig[9:8], h0.dig[11:10], h0.dig[13:12], h0.dig[15:14],
               h1.dig[1:0], h1.dig[3:2], h1.dig[5:4], h1.dig[7:6],
               h0.dig[1:0], h0.dig[3:2], h0.dig[5:4], h0.dig[7:6]};
    end

    always_comb begin
        for (int i = 0; i < ROLL_W; i++) begin
            rev[ROLL_W-1-i] = r_acc[i];
        end
        pv = ({r_f0[7:0], 32'd0})
           ^ ({8'd0, r_f0[15:8], 24'd0})
           ^ ({20'd0, r_f0[19:16], 16'd0})
           ^ ({20'd0, r_f1[7:0], 12'd0})
           ^ ({28'd0, r_f1[15:8], 4'd0});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            o_valid <= 1'b0;
        end else begin
            if (out_load) begin
                o_valid <= 1'b1;
            end else if (o_valid && i_ready) begin
                o_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (o_pop) begin
                        if (!i_job.dec || pair_err != ST_STORED) begin
                            o_status       <= i_job.dec ? pair_err : i_job.status;
                            o_fixed_code   <= '0;
                            o_button       <= '0;
                            o_rolling      <= '0;
                            o_packed_value <= '0;
                        end else begin
                            r_seq   <= seq;
                            r_f0    <= h0.fix;
                            r_f1    <= h1.fix;
                            r_acc   <= '0;
                            r_cnt   <= '0;
                            r_state <= S_ACC;
                        end
                    end
                end
                S_ACC: begin
                    // acc = acc * 3 + next digit
                    r_acc <= {r_acc[ACC_W-2:0], 1'b0} + r_acc
                           + {{(ACC_W-2){1'b0}}, r_seq[2*SEQ_N-1 -: 2]};
                    r_seq <= {r_seq[2*SEQ_N-3:0], 2'b00};
                    r_cnt <= r_cnt + 5'd1;
                    if (r_cnt == 5'(SEQ_N - 1)) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                        if (r_acc[ACC_W-1]) begin
                            o_status       <= ST_OVERFLOW;
                            o_fixed_code   <= '0;
                            o_button       <= '0;
                            o_rolling      <= '0;
                            o_packed_value <= '0;
                        end else begin
                            o_status       <= ST_DECODED;
                            o_fixed_code   <= {r_f0, r_f1};
                            o_button       <= r_f0[19:12];
                            o_rolling      <= rev;
                            o_packed_value <= pv;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

@@ rtl/rcpd_chk.sv @@
module rcpd_chk (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         o_m_axis_tvalid,
    input logic         i_m_axis_tready,
    input logic [119:0] o_m_axis_tdata,
    input logic [3:0]   o_m_axis_tuser
);
    import rcpd_pkg::*;

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
        else $error("stalled result changed");

    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> o_m_axis_tuser <= ST_OVERFLOW)
        else $error("status code out of range");

    // only a decoded pair carries data
    a_zero_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser != ST_DECODED |-> o_m_axis_tdata == '0)
        else $error("data on a non-decoded result");

    // button is the top byte of the first fixed word
    a_button: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser == ST_DECODED |->
            o_m_axis_tdata[47:40] == o_m_axis_tdata[39:32])
        else $error("button does not match fixed code");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid right after reset");

endmodule

bind rolling_code_packet_pair_decoder_top rcpd_chk u_rcpd_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser)
);

@@ sim/rolling_code_packet_pair_decoder_top_tb.sv @@
module rolling_code_packet_pair_decoder_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rcpd_pkg::*;

    // cycles without any transaction, while work is pending, before giving up
    localparam int STALL_LIMIT = 3000;
    // long receiver hold-off: starts once this many packets went in
    localparam int HOLD_AT     = 150;
    localparam int HOLD_CYCLES = 400;
    // cycles to watch for stray results once everything has come back
    localparam int TAIL_CYCLES = 40;

    // header nibbles with a table entry, and the ones without
    localparam logic [3:0] GOOD_NIB [9] = '{4'd0, 4'd1, 4'd2, 4'd4, 4'd5, 4'd6,
                                           4'd8, 4'd9, 4'd10};
    localparam logic [3:0] BAD_NIB  [7] = '{4'd3, 4'd7, 4'd11, 4'd12, 4'd13, 4'd14, 4'd15};

    // invert nibble -> {no entry, invert mask for words 2..0}
    localparam logic [3:0] INV_MAP [16] = '{4'h3, 4'h2, 4'h4, 4'h8, 4'h7, 4'h5, 4'h6, 4'h8,
                                           4'h1, 4'h0, 4'h5, 4'h8, 4'h8, 4'h8, 4'h8, 4'h8};

    // order nibble -> {no entry, slot of word 2, slot of word 1, slot of word 0}
    localparam logic [6:0] ORD_MAP [16] = '{
        {1'b0, 2'd1, 2'd2, 2'd0}, {1'b0, 2'd1, 2'd0, 2'd2},
        {1'b0, 2'd2, 2'd1, 2'd0}, 7'h40,
        {1'b0, 2'd0, 2'd2, 2'd1}, {1'b0, 2'd2, 2'd0, 2'd1},
        {1'b0, 2'd0, 2'd1, 2'd2}, 7'h40,
        {1'b0, 2'd0, 2'd2, 2'd1}, {1'b0, 2'd0, 2'd1, 2'd2},
        {1'b0, 2'd2, 2'd1, 2'd0}, 7'h40,
        7'h40, 7'h40, 7'h40, 7'h40};

    // per-half decode errors used to break a pair on purpose
    localparam logic [3:0] HALF_ERRS [3] = '{ST_BAD_INV, ST_BAD_ORD, ST_DIGIT3};

    // one decoded half: error, nine ternary digits, 20-bit fixed word
    typedef struct packed {
        logic [3:0]       err;
        logic [8:0][1:0]  dig;
        logic [19:0]      fix;
    } t_pred_half;

    // one result transaction as the block should send it
    typedef struct packed {
        logic [3:0]  status;
        logic [39:0] fixed_code;
        logic [7:0]  button;
        logic [27:0] rolling;
        logic [39:0] xor_code;
    } t_pred_result;

    logic         i_clk     = 1'b0;
    logic         i_rst_n   = 1'b0;
    logic         pkt_valid = 1'b0;
    logic [47:0]  pkt_data  = '0;
    logic         res_ready = 1'b0;
    logic         o_s_axis_tready;
    logic         o_m_axis_tvalid;
    logic [119:0] o_m_axis_tdata;
    logic [3:0]   o_m_axis_tuser;

    // packets waiting for the driver, results waiting for the block
    logic [41:0]  pkt_q [$];
    t_pred_result expected_q [$];

    // pairing state of the predictor
    logic [41:0]  pair_first = '0;
    logic [1:0]   pair_flags = '0;

    int           send_idle_pct = 0;
    int           stall_pct     = 0;
    int           pkts_accepted = 0;
    int           mismatch_cnt  = 0;
    int           quiet_cycles  = 0;
    int           hold_left     = 0;
    bit           hold_done     = 1'b0;
    t_pred_result head_res;

    rolling_code_packet_pair_decoder_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (pkt_valid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (pkt_data),        // [41:0] packet, rest zero
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (res_ready),
        .o_m_axis_tdata  (o_m_axis_tdata),  // [39:0] fixed_code, [47:40] button,
                                            // [75:48] rolling, [115:76] xor code
        .o_m_axis_tuser  (o_m_axis_tuser)   // [3:0] status
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // deinterleave, invert and reorder one half, then pull its digits
    function automatic t_pred_half split_half(input logic [41:0] pk);
        t_pred_half      h;
        logic [2:0][9:0] w;
        logic [2:0][9:0] part;
        logic [7:0]      hdr;
        logic [3:0]      inv;
        logic [6:0]      ord;
        h    = '0;
        w    = '0;
        part = '0;
        hdr  = pk[37:30];
        inv  = INV_MAP[hdr[3:0]];
        ord  = ORD_MAP[hdr[7:4]];
        for (int i = 0; i < 10; i++) begin
            w[2][i] = pk[3*i];
            w[1][i] = pk[3*i+1];
            w[0][i] = pk[3*i+2];
        end
        if (inv[3]) begin
            h.err = ST_BAD_INV;
            return h;
        end
        for (int i = 0; i < 3; i++) begin
            if (inv[i]) begin
                w[i] = ~w[i];
            end
        end
        if (ord[6]) begin
            h.err = ST_BAD_ORD;
            return h;
        end
        for (int i = 0; i < 3; i++) begin
            part[ord[2*i+:2]] = w[i];
        end
        // four digits from the header, five from the third word
        for (int i = 0; i < 4; i++) begin
            h.dig[i] = hdr[6-2*i+:2];
        end
        for (int i = 0; i < 5; i++) begin
            h.dig[4+i] = part[2][8-2*i+:2];
        end
        h.err = ST_STORED;
        for (int i = 0; i < 9; i++) begin
            if (h.dig[i] == 2'd3) begin
                h.err = ST_DIGIT3;
            end
        end
        h.fix = {part[0], part[1]};
        return h;
    endfunction

    // full decode of a first and a second half
    function automatic t_pred_result decode_pair(input logic [41:0] first_pk,
                                                 input logic [41:0] second_pk);
        t_pred_result r;
        t_pred_half   h0;
        t_pred_half   h1;
        logic [31:0]  acc;
        logic [27:0]  rev;
        r  = '0;
        h0 = split_half(first_pk);
        if (h0.err != ST_STORED) begin
            r.status = h0.err;
            return r;
        end
        h1 = split_half(second_pk);
        if (h1.err != ST_STORED) begin
            r.status = h1.err;
            return r;
        end
        // digit order: last word digits, then word digits, then header digits
        acc = 32'(h1.dig[8]);
        acc = acc * 3 + 32'(h0.dig[8]);
        for (int i = 4; i < 8; i++) acc = acc * 3 + 32'(h1.dig[i]);
        for (int i = 4; i < 8; i++) acc = acc * 3 + 32'(h0.dig[i]);
        for (int i = 0; i < 4; i++) acc = acc * 3 + 32'(h1.dig[i]);
        for (int i = 0; i < 4; i++) acc = acc * 3 + 32'(h0.dig[i]);
        if (acc >= 32'h1000_0000) begin
            r.status = ST_OVERFLOW;
            return r;
        end
        for (int i = 0; i < 28; i++) begin
            rev[27-i] = acc[i];
        end
        r.status     = ST_DECODED;
        r.fixed_code = {h0.fix, h1.fix};
        r.button     = h0.fix[19:12];
        r.rolling    = rev;
        // the second word is only 20 bits, so nothing lands in the low nibble
        r.xor_code   = (40'(h0.fix[7:0]) << 32) ^ (40'(h0.fix[15:8]) << 24)
                     ^ (40'(h0.fix[19:16]) << 16) ^ (40'(h1.fix[7:0]) << 12)
                     ^ (40'(h1.fix[15:8]) << 4);
        return r;
    endfunction

    // advance the pairing state by one accepted packet and queue its result
    task automatic track_packet(input logic [41:0] pk);
        t_pred_result r;
        logic [1:0]   half_bit;
        r = '0;
        if (pk[39:38] != 2'b00) begin
            pair_flags = 2'b00;
            r.status   = ST_ID;
        end else begin
            half_bit = (pk[41:40] != 2'b00) ? 2'b10 : 2'b01;
            if ((pair_flags & half_bit) != 2'b00) begin
                pair_flags = 2'b00;
                r.status   = ST_REPEAT;
            end else begin
                pair_flags = pair_flags | half_bit;
                if (half_bit == 2'b01) begin
                    pair_first = pk;
                end
                if (pair_flags != 2'b11) begin
                    r.status = ST_STORED;
                end else if (half_bit == 2'b01) begin
                    // first half closed the pair: it restarts pairing
                    pair_flags = 2'b01;
                    r.status   = ST_ORDER;
                end else begin
                    pair_flags = 2'b00;
                    r          = decode_pair(pair_first, pk);
                end
            end
        end
        expected_q.push_back(r);
    endtask

    // random half of the given type whose own decode ends with the given status
    function automatic logic [41:0] make_half(input logic [1:0] kind, input logic [3:0] want);
        logic [41:0] pk;
        logic [3:0]  inv_n;
        logic [3:0]  ord_n;
        t_pred_half  h;
        do begin
            inv_n = GOOD_NIB[$urandom_range(8)];
            ord_n = GOOD_NIB[$urandom_range(8)];
            if (want == ST_BAD_INV) begin
                inv_n = BAD_NIB[$urandom_range(6)];
                ord_n = 4'($urandom);
            end
            if (want == ST_BAD_ORD) begin
                ord_n = BAD_NIB[$urandom_range(6)];
            end
            pk = {kind, 2'b00, ord_n, inv_n, 30'($urandom)};
            h  = split_half(pk);
        end while (h.err != want);
        return pk;
    endfunction

    function automatic logic [1:0] second_kind();
        return 2'($urandom_range(3, 1));
    endfunction

    // well-formed pair whose decode ends with the given status
    task automatic add_pair(input logic [3:0] want, input logic [1:0] kind);
        logic [41:0]  a;
        logic [41:0]  b;
        t_pred_result r;
        do begin
            a = make_half(2'd0, ST_STORED);
            b = make_half(kind, ST_STORED);
            r = decode_pair(a, b);
        end while (r.status != want);
        pkt_q.push_back(a);
        pkt_q.push_back(b);
    endtask

    // random traffic, mostly clean pairs, some broken sequences and noise
    task automatic add_traffic(input int n);
        int          added;
        int          sel;
        logic [41:0] pk;
        logic [3:0]  err;
        added = 0;
        while (added < n) begin
            sel = $urandom_range(99);
            if (sel < 55) begin
                pkt_q.push_back(make_half(2'd0, ST_STORED));
                pkt_q.push_back(make_half(second_kind(), ST_STORED));
                added += 2;
            end else if (sel < 70) begin
                err = HALF_ERRS[$urandom_range(2)];
                if ($urandom_range(1) == 0) begin
                    pkt_q.push_back(make_half(2'd0, err));
                    pkt_q.push_back(make_half(second_kind(), ST_STORED));
                end else begin
                    pkt_q.push_back(make_half(2'd0, ST_STORED));
                    pkt_q.push_back(make_half(second_kind(), err));
                end
                added += 2;
            end else if (sel < 77) begin
                // second half first, then a first half, then the closing second
                pkt_q.push_back(make_half(second_kind(), ST_STORED));
                pkt_q.push_back(make_half(2'd0, ST_STORED));
                pkt_q.push_back(make_half(second_kind(), ST_STORED));
                added += 3;
            end else if (sel < 82) begin
                if ($urandom_range(1) == 0) begin
                    pkt_q.push_back(make_half(2'd0, ST_STORED));
                    pkt_q.push_back(make_half(2'd0, ST_STORED));
                end else begin
                    pkt_q.push_back(make_half(second_kind(), ST_STORED));
                    pkt_q.push_back(make_half(second_kind(), ST_STORED));
                end
                added += 2;
            end else if (sel < 88) begin
                pk        = 42'({$urandom, $urandom});
                pk[39:38] = 2'($urandom_range(3, 1));
                pkt_q.push_back(pk);
                added += 1;
            end else begin
                pkt_q.push_back(42'({$urandom, $urandom}));
                added += 1;
            end
        end
    endtask

    task automatic check_field(input string name, input logic [39:0] want,
                               input logic [39:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
            mismatch_cnt++;
        end
    endtask

    // driver: offers the next packet, holds it until the block takes it
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pkt_valid <= 1'b0;
        end else begin
            if (pkt_valid && o_s_axis_tready) begin
                track_packet(pkt_data[41:0]);
                pkts_accepted++;
            end
            if (!pkt_valid || o_s_axis_tready) begin
                if (pkt_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    pkt_valid <= 1'b1;
                    pkt_data  <= {6'b0, pkt_q.pop_front()};
                end else begin
                    pkt_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: checks each result transaction and drives the receiver ready
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_ready <= 1'b0;
        end else begin
            if (o_m_axis_tvalid && res_ready) begin
                if (expected_q.size() == 0) begin
                    $error("result transaction with no packet waiting for one");
                    mismatch_cnt++;
                end else begin
                    head_res = expected_q.pop_front();
                    check_field("status", 40'(head_res.status), 40'(o_m_axis_tuser));
                    check_field("fixed_code", head_res.fixed_code, o_m_axis_tdata[39:0]);
                    check_field("button", 40'(head_res.button), 40'(o_m_axis_tdata[47:40]));
                    check_field("rolling", 40'(head_res.rolling), 40'(o_m_axis_tdata[75:48]));
                    check_field("packed_value", head_res.xor_code, o_m_axis_tdata[115:76]);
                end
            end
            // one long hold-off so the job queue fills and input backs up
            if (hold_left != 0) begin
                hold_left <= hold_left - 1;
                res_ready <= 1'b0;
            end else if (!hold_done && pkts_accepted >= HOLD_AT) begin
                hold_done <= 1'b1;
                hold_left <= HOLD_CYCLES;
                res_ready <= 1'b0;
            end else begin
                res_ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    // watchdog: only counts while something is still owed
    always @(posedge i_clk) begin
        if ((pkt_valid && o_s_axis_tready) || (o_m_axis_tvalid && res_ready)) begin
            quiet_cycles <= 0;
        end else if (pkt_q.size() != 0 || pkt_valid || expected_q.size() != 0) begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extremes of the packet
        pkt_q.push_back(42'h0);
        pkt_q.push_back(42'h3FF_FFFF_FFFF);
        // second half before first, then wrong order, then a clean close
        pkt_q.push_back(make_half(2'd1, ST_STORED));
        pkt_q.push_back(make_half(2'd0, ST_STORED));
        pkt_q.push_back(make_half(2'd2, ST_STORED));
        // clean decode and rolling count overflow
        add_pair(ST_DECODED, 2'd3);
        add_pair(ST_OVERFLOW, 2'd1);
        // repeated first half, repeated second half
        pkt_q.push_back(make_half(2'd0, ST_STORED));
        pkt_q.push_back(make_half(2'd0, ST_STORED));
        pkt_q.push_back(make_half(2'd2, ST_STORED));
        pkt_q.push_back(make_half(2'd3, ST_STORED));
        // table and digit errors in either half
        pkt_q.push_back(make_half(2'd0, ST_BAD_INV));
        pkt_q.push_back(make_half(2'd1, ST_STORED));
        pkt_q.push_back(make_half(2'd0, ST_STORED));
        pkt_q.push_back(make_half(2'd2, ST_BAD_ORD));
        pkt_q.push_back(make_half(2'd0, ST_DIGIT3));
        pkt_q.push_back(make_half(2'd3, ST_STORED));
        pkt_q.push_back(make_half(2'd0, ST_STORED));
        pkt_q.push_back(make_half(2'd1, ST_DIGIT3));
        // nonzero frame id in the middle of a pair clears it
        pkt_q.push_back(make_half(2'd0, ST_STORED));
        pkt_q.push_back(make_half(2'd2, ST_STORED) | 42'h40_0000_0000);

        // random phases: no idling, sender idle, receiver stall, both
        add_traffic(330);
        while (pkt_q.size() != 0) @(posedge i_clk);
        send_idle_pct = 53;
        add_traffic(350);
        while (pkt_q.size() != 0) @(posedge i_clk);
        send_idle_pct = 0;
        stall_pct     = 53;
        add_traffic(350);
        while (pkt_q.size() != 0) @(posedge i_clk);
        send_idle_pct = 13;
        stall_pct     = 13;
        add_traffic(350);

        // drain, then watch for stray results
        while (pkt_q.size() != 0 || pkt_valid || expected_q.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatch_cnt == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
